FILE: rtl/sha1_pkg.sv
package sha1_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } state_t;

    // What the compression of the current block reads for each schedule word.
    typedef enum logic [1:0] {
        BLK_FULL,      // all sixteen words from the block memory
        BLK_PAD_LEN,   // stored words, pad marker, zeros, bit length
        BLK_PAD_ONLY,  // stored words, pad marker, zeros; length goes in a further block
        BLK_LEN_ONLY   // zeros and the bit length
    } blk_kind_t;

    typedef logic [31:0] word_t;

    localparam int WORD_COUNT  = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t INIT_CHAIN [WORD_COUNT] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    function automatic word_t round_k(input logic [6:0] t);
        word_t k;
        priority if (t < 7'd20) k = K_00_19;
        else if (t < 7'd40)     k = K_20_39;
        else if (t < 7'd60)     k = K_40_59;
        else                    k = K_60_79;
        return k;
    endfunction

    function automatic word_t round_f(input logic [6:0] t, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        priority if (t < 7'd20) f = (b & c) | (~b & d);
        else if (t < 7'd40)     f = b ^ c ^ d;
        else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
        else                    f = b ^ c ^ d;
        return f;
    endfunction

endpackage

FILE: rtl/sha1_stream_hasher_top.sv
// Streaming SHA-1 hasher. Each input transfer carries either one message byte
// (req_type 0) or a finish request (req_type 1). Bytes are taken while idle;
// the byte that completes a 64-byte block starts the compression, which runs one
// round per cycle and holds the input until its last round is done. A finish
// request pads the message and compresses one block, or two when 56 or more
// bytes of the last block are filled,
// then sends the five digest words A to E as five output transfers,
// one per cycle while out_ready is high, the fifth marked by last_word. The
// engine then starts a new message; the input reopens as the fifth word is
// loaded into the output register, before it has been taken.
module sha1_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1_pkg::state_t    state_reg, state_next;
    sha1_pkg::blk_kind_t kind_reg, kind_next;

    logic [6:0]  t_reg, t_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [63:0] msg_bits_reg, msg_bits_next;
    logic [31:0] wbuf_reg, wbuf_next;

    sha1_pkg::word_t chain_reg [sha1_pkg::WORD_COUNT];
    sha1_pkg::word_t chain_next [sha1_pkg::WORD_COUNT];
    sha1_pkg::word_t w_reg [sha1_pkg::BLOCK_WORDS];
    sha1_pkg::word_t w_next [sha1_pkg::BLOCK_WORDS];

    sha1_pkg::word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1_pkg::word_t a_next, b_next, c_next, d_next, e_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] digest_reg, digest_next;
    logic [2:0]  index_reg, index_next;
    logic        last_reg, last_next;

    // The message block lives in a 16-word memory with a registered read port.
    // Words are written whole, once their fourth byte arrives.
    sha1_pkg::word_t block_mem [sha1_pkg::BLOCK_WORDS];
    sha1_pkg::word_t rd_data_reg;
    logic [3:0]      rd_addr;
    logic            mem_we;
    sha1_pkg::word_t mem_wdata;

    logic [5:0]      pos;
    logic [3:0]      cur_word;
    logic [1:0]      lane;
    logic [3:0]      idx;
    sha1_pkg::word_t pad_word;
    sha1_pkg::word_t blk_word;
    sha1_pkg::word_t sched_word;
    sha1_pkg::word_t wt;
    sha1_pkg::word_t round_sum;
    logic            last_round;

    assign pos      = msg_bits_reg[8:3];
    assign cur_word = msg_bits_reg[8:5];
    assign lane     = msg_bits_reg[4:3];
    assign idx      = t_reg[3:0];

    assign in_ready    = (state_reg == sha1_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

    // The word that holds the pad marker keeps the bytes already received.
    always_comb
    begin
        unique case (lane)
            2'd0: pad_word = {sha1_pkg::PAD_BYTE, 24'd0};
            2'd1: pad_word = {wbuf_reg[31:24], sha1_pkg::PAD_BYTE, 16'd0};
            2'd2: pad_word = {wbuf_reg[31:16], sha1_pkg::PAD_BYTE, 8'd0};
            2'd3: pad_word = {wbuf_reg[31:8], sha1_pkg::PAD_BYTE};
            default: pad_word = '0;
        endcase
    end

    // Select the block word for the first sixteen rounds. Padding words are
    // produced on the fly rather than written into the memory.
    always_comb
    begin
        unique case (kind_reg)
            sha1_pkg::BLK_FULL:
            begin
                blk_word = rd_data_reg;
            end
            sha1_pkg::BLK_LEN_ONLY:
            begin
                if (idx == 4'd14)
                    blk_word = msg_bits_reg[63:32];
                else if (idx == 4'd15)
                    blk_word = msg_bits_reg[31:0];
                else
                    blk_word = '0;
            end
            sha1_pkg::BLK_PAD_LEN, sha1_pkg::BLK_PAD_ONLY:
            begin
                if (idx < cur_word)
                    blk_word = rd_data_reg;
                else if (idx == cur_word)
                    blk_word = pad_word;
                else if (kind_reg == sha1_pkg::BLK_PAD_LEN && idx == 4'd14)
                    blk_word = msg_bits_reg[63:32];
                else if (kind_reg == sha1_pkg::BLK_PAD_LEN && idx == 4'd15)
                    blk_word = msg_bits_reg[31:0];
                else
                    blk_word = '0;
            end
            default: blk_word = '0;
        endcase
    end

    always_comb
    begin
        sched_word = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        sched_word = {sched_word[30:0], sched_word[31]};
        wt         = (t_reg < 7'd16) ? blk_word : sched_word;
        round_sum  = {a_reg[26:0], a_reg[31:27]}
                     + sha1_pkg::round_f(t_reg, b_reg, c_reg, d_reg)
                     + e_reg + sha1_pkg::round_k(t_reg) + wt;
        last_round = (t_reg == 7'(sha1_pkg::ROUNDS - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        t_next         = t_reg;
        emit_idx_next  = emit_idx_reg;
        msg_bits_next  = msg_bits_reg;
        wbuf_next      = wbuf_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        chain_next     = chain_reg;
        w_next         = w_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digest_next    = digest_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        rd_addr        = 4'd0;
        mem_we         = 1'b0;
        mem_wdata      = {wbuf_reg[31:8], data_byte};

        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == sha1_pkg::REQ_DATA)
                    begin
                        unique case (lane)
                            2'd0: wbuf_next[31:24] = data_byte;
                            2'd1: wbuf_next[23:16] = data_byte;
                            2'd2: wbuf_next[15:8]  = data_byte;
                            2'd3: wbuf_next[7:0]   = data_byte;
                            default: wbuf_next = wbuf_reg;
                        endcase
                        mem_we        = (lane == 2'd3);
                        msg_bits_next = msg_bits_reg + 64'd8;
                        if (pos == 6'd63)
                        begin
                            kind_next  = sha1_pkg::BLK_FULL;
                            state_next = sha1_pkg::ST_ROUND;
                        end
                    end
                    else
                    begin
                        // Fewer than nine free bytes leave no room for the length.
                        kind_next  = (pos >= 6'd56) ? sha1_pkg::BLK_PAD_ONLY
                                                    : sha1_pkg::BLK_PAD_LEN;
                        state_next = sha1_pkg::ST_ROUND;
                    end
                    t_next = '0;
                    a_next = chain_reg[0];
                    b_next = chain_reg[1];
                    c_next = chain_reg[2];
                    d_next = chain_reg[3];
                    e_next = chain_reg[4];
                end
            end

            sha1_pkg::ST_ROUND:
            begin
                // Prefetch the block word for the next round.
                rd_addr = idx + 4'd1;
                for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++)
                    w_next[i] = w_reg[i + 1];
                w_next[sha1_pkg::BLOCK_WORDS - 1] = wt;
                a_next = round_sum;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                t_next = t_reg + 7'd1;
                if (last_round)
                begin
                    chain_next[0] = chain_reg[0] + round_sum;
                    chain_next[1] = chain_reg[1] + a_reg;
                    chain_next[2] = chain_reg[2] + {b_reg[1:0], b_reg[31:2]};
                    chain_next[3] = chain_reg[3] + c_reg;
                    chain_next[4] = chain_reg[4] + d_reg;
                    unique case (kind_reg)
                        sha1_pkg::BLK_FULL:
                        begin
                            state_next = sha1_pkg::ST_IDLE;
                        end
                        sha1_pkg::BLK_PAD_ONLY:
                        begin
                            kind_next = sha1_pkg::BLK_LEN_ONLY;
                            t_next    = '0;
                            a_next    = chain_next[0];
                            b_next    = chain_next[1];
                            c_next    = chain_next[2];
                            d_next    = chain_next[3];
                            e_next    = chain_next[4];
                        end
                        sha1_pkg::BLK_PAD_LEN, sha1_pkg::BLK_LEN_ONLY:
                        begin
                            emit_idx_next = '0;
                            state_next    = sha1_pkg::ST_EMIT;
                        end
                        default: state_next = sha1_pkg::ST_IDLE;
                    endcase
                end
            end

            sha1_pkg::ST_EMIT:
            begin
                // The chaining words rotate so the next word to send always sits in the first slot.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = chain_reg[0];
                    index_next     = emit_idx_reg;
                    last_next      = (emit_idx_reg == 3'(sha1_pkg::WORD_COUNT - 1));
                    for (int i = 0; i < sha1_pkg::WORD_COUNT - 1; i++)
                        chain_next[i] = chain_reg[i + 1];
                    chain_next[sha1_pkg::WORD_COUNT - 1] = chain_reg[0];
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'(sha1_pkg::WORD_COUNT - 1))
                    begin
                        chain_next    = sha1_pkg::INIT_CHAIN;
                        msg_bits_next = '0;
                        state_next    = sha1_pkg::ST_IDLE;
                    end
                end
            end

            default: state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ST_IDLE;
            kind_reg      <= sha1_pkg::BLK_FULL;
            t_reg         <= '0;
            emit_idx_reg  <= '0;
            msg_bits_reg  <= '0;
            chain_reg     <= sha1_pkg::INIT_CHAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            t_reg         <= t_next;
            emit_idx_reg  <= emit_idx_next;
            msg_bits_reg  <= msg_bits_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wbuf_reg   <= wbuf_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        w_reg      <= w_next;
        digest_reg <= digest_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            block_mem[cur_word] <= mem_wdata;
        rd_data_reg <= block_mem[rd_addr];
    end

endmodule
